/* rtl/core/byte_memory_load_store_compare_top_assert.svh */
// assertion macros shared by the byte memory block
// each macro takes a label, a condition and a consequence, sampled on clk_i
`ifndef BYTE_MEMORY_LOAD_STORE_COMPARE_TOP_ASSERT_SVH
`define BYTE_MEMORY_LOAD_STORE_COMPARE_TOP_ASSERT_SVH

// same-cycle implication
`define BMLSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bmlsc assertion failed");

// next-cycle implication
`define BMLSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bmlsc assertion failed");

`endif

/* rtl/core/bmlsc_pkg.sv */
`default_nettype none

package bmlsc_pkg;

  localparam int unsigned MEM_AW    = 10;
  localparam int unsigned LANE_BITS = 2;
  localparam int unsigned LANES     = 1 << LANE_BITS;
  localparam int unsigned ROW_BITS  = MEM_AW - LANE_BITS;
  localparam int unsigned ROWS      = 1 << ROW_BITS;

  typedef enum logic [2:0] {
    FUNC_LD8      = 3'd0,
    FUNC_LD16     = 3'd1,
    FUNC_LD32     = 3'd2,
    FUNC_ST8      = 3'd3,
    FUNC_ST16     = 3'd4,
    FUNC_ST32     = 3'd5,
    FUNC_MEMCMP   = 3'd6,
    FUNC_SLICECMP = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_DONE
  } state_e;

  // controller to compare walker
  typedef struct packed {
    logic              start;
    logic              active;
    logic              slice;
    logic [MEM_AW-1:0] a_start;
    logic [MEM_AW-1:0] a_end;
    logic [MEM_AW-1:0] b_start;
    logic [MEM_AW-1:0] b_end;
  } walk_ctrl_t;

  // compare walker to controller
  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } walk_stat_t;

endpackage

`default_nettype wire

/* rtl/core/byte_memory_load_store_compare_top.sv */
// byte memory with loads, stores and two byte-wise compares
//
// input channel: in_valid_i / in_stall_o carry one item (func, addresses,
// store value); output channel: out_valid_o / out_stall_i carry one result.
// an item moves when valid is high and stall is low at a rising clock edge.
//
// stores: written at the accept edge, no result; the next item may follow
// in the very next cycle.
// loads: the ram read register takes the row at accept, then the output
// register takes the value; a following item is taken as it moves there, so
// back-to-back loads run one per cycle while the receiver takes results.
// memcmp and slice compare: one byte pair per cycle from the two read ports
// of the row memory, ending early when a difference turns up.
// reset: the memory is swept to zero one 4-byte row per cycle over all
// 2^(MEM_AW-2) rows (256 at MEM_AW = 10); no item is taken until it ends.
// a stalled receiver holds the output register; a load or compare result
// then waits in the block and no new item is taken until it can move.
`default_nettype none

`include "byte_memory_load_store_compare_top_assert.svh"

module byte_memory_load_store_compare_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [31:0] addr_a_i,
  input  wire logic [31:0] end_a_i,
  input  wire logic [31:0] start_b_i,
  input  wire logic [31:0] end_b_i,
  input  wire logic [31:0] store_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [31:0] result_o
);
  import bmlsc_pkg::*;

  state_e state_q, state_d;

  // clearing sweep row counter
  logic [ROW_BITS-1:0] clr_q, clr_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] result_q, result_d;

  // load bookkeeping and compare hold
  func_e                ld_func_q;
  logic [LANE_BITS-1:0] ld_lane_q;
  logic [31:0]          hold_q;

  // memory port signals
  logic                  mem_we;
  logic [ROW_BITS-1:0]   mem_wrow;
  logic [LANES-1:0]      mem_wbe;
  logic [LANES*8-1:0]    mem_wdata;
  logic                  mem_re;
  logic [ROW_BITS-1:0]   mem_rrow_a;
  logic [LANES*8-1:0]    rdata_a, rdata_b;

  logic                  ld_rd;
  logic                  walk_start;
  logic                  walk_issue;
  logic [ROW_BITS-1:0]   walk_row_a, walk_row_b;
  walk_ctrl_t            wctrl;
  walk_stat_t            wstat;

  func_e                 func;
  logic [MEM_AW-1:0]     addr_m;
  logic                  out_free;
  logic                  can_take;
  logic                  accept;
  logic                  load_fire;
  logic                  done_fire;
  logic [31:0]           load_data;

  assign func     = func_e'(func_i);
  assign addr_m   = addr_a_i[MEM_AW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  // an item is taken when idle, or while a load result moves out
  assign can_take = (state_q == ST_IDLE) || ((state_q == ST_LOAD) && out_free);
  assign accept   = in_valid_i && can_take;

  assign wctrl.start   = walk_start;
  assign wctrl.active  = (state_q == ST_CMP);
  assign wctrl.slice   = (func == FUNC_SLICECMP);
  assign wctrl.a_start = addr_m;
  assign wctrl.a_end   = end_a_i[MEM_AW-1:0];
  assign wctrl.b_start = start_b_i[MEM_AW-1:0];
  assign wctrl.b_end   = end_b_i[MEM_AW-1:0];

  // port a serves loads on accept and the walker otherwise
  assign mem_re     = ld_rd || walk_issue;
  assign mem_rrow_a = ld_rd ? addr_m[MEM_AW-1:LANE_BITS] : walk_row_a;

  // little-endian extraction, zero-extended
  always_comb begin
    load_data = '0;
    unique case (ld_func_q)
      FUNC_LD8:  load_data = {24'b0, rdata_a[ld_lane_q*8 +: 8]};
      FUNC_LD16: load_data = {16'b0, (ld_lane_q[1] ? rdata_a[31:16] : rdata_a[15:0])};
      default:   load_data = rdata_a;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    in_stall_o = !can_take;
    mem_we     = 1'b0;
    mem_wrow   = addr_m[MEM_AW-1:LANE_BITS];
    mem_wbe    = '0;
    mem_wdata  = '0;
    ld_rd      = 1'b0;
    walk_start = 1'b0;
    load_fire  = 1'b0;
    done_fire  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_wrow = clr_q;
        mem_wbe  = '1;
        clr_d    = clr_q + ROW_BITS'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      ST_LOAD: begin
        if (out_free) begin
          load_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_CMP: begin
        if (wstat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (accept) begin
      unique case (func)
        FUNC_LD8, FUNC_LD16, FUNC_LD32: begin
          ld_rd   = 1'b1;
          state_d = ST_LOAD;
        end
        FUNC_ST8: begin
          mem_we    = 1'b1;
          mem_wbe   = LANES'(1) << addr_m[LANE_BITS-1:0];
          mem_wdata = {4{store_value_i[7:0]}};
          state_d   = ST_IDLE;
        end
        FUNC_ST16: begin
          mem_we    = 1'b1;
          mem_wbe   = addr_m[1] ? 4'b1100 : 4'b0011;
          mem_wdata = {2{store_value_i[15:0]}};
          state_d   = ST_IDLE;
        end
        FUNC_ST32: begin
          mem_we    = 1'b1;
          mem_wbe   = '1;
          mem_wdata = store_value_i;
          state_d   = ST_IDLE;
        end
        FUNC_MEMCMP, FUNC_SLICECMP: begin
          walk_start = 1'b1;
          state_d    = ST_CMP;
        end
      endcase
    end
  end

  // output register: filled by a load or compare, drained by the receiver
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    if (load_fire) begin
      out_valid_d = 1'b1;
      result_d    = load_data;
    end else if (done_fire) begin
      out_valid_d = 1'b1;
      result_d    = hold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    if (ld_rd) begin
      ld_func_q <= func;
      ld_lane_q <= addr_m[LANE_BITS-1:0];
    end
    if (wstat.done) begin
      hold_q <= wstat.result;
    end
  end

  bmlsc_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .wrow_i    (mem_wrow),
    .wbe_i     (mem_wbe),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .rrow_a_i  (mem_rrow_a),
    .rrow_b_i  (walk_row_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  bmlsc_walk u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (wctrl),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .issue_o   (walk_issue),
    .rrow_a_o  (walk_row_a),
    .rrow_b_o  (walk_row_b),
    .stat_o    (wstat)
  );

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // no item enters during the clearing sweep
  `BMLSC_ASSERT_SAME(a_no_take_in_clear, state_q == ST_CLEAR, in_stall_o)
  // the walker finishes only while a compare runs
  `BMLSC_ASSERT_SAME(a_done_in_cmp, wstat.done, state_q == ST_CMP)
  // a load result that can move lands in the output register
  `BMLSC_ASSERT_NEXT(a_load_lands, (state_q == ST_LOAD) && out_free, out_valid_q)
  // the walker and a load never share the read port
  `BMLSC_ASSERT_SAME(a_port_excl, walk_issue, !ld_rd)

endmodule

`default_nettype wire

/* rtl/core/bmlsc_ram.sv */
`default_nettype none

module bmlsc_ram (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [bmlsc_pkg::ROW_BITS-1:0]    wrow_i,
  input  wire logic [bmlsc_pkg::LANES-1:0]       wbe_i,
  input  wire logic [bmlsc_pkg::LANES*8-1:0]     wdata_i,
  input  wire logic                              re_i,
  input  wire logic [bmlsc_pkg::ROW_BITS-1:0]    rrow_a_i,
  input  wire logic [bmlsc_pkg::ROW_BITS-1:0]    rrow_b_i,
  output logic      [bmlsc_pkg::LANES*8-1:0]     rdata_a_o,
  output logic      [bmlsc_pkg::LANES*8-1:0]     rdata_b_o
);
  import bmlsc_pkg::*;

  logic [LANES-1:0][7:0] mem_q [ROWS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int l = 0; l < LANES; l++) begin
        if (wbe_i[l]) begin
          mem_q[wrow_i][l] <= wdata_i[l*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[rrow_a_i];
      rdata_b_o <= mem_q[rrow_b_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bmlsc_walk.sv */
`default_nettype none

module bmlsc_walk (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bmlsc_pkg::walk_ctrl_t             ctrl_i,
  input  wire logic [bmlsc_pkg::LANES*8-1:0]     rdata_a_i,
  input  wire logic [bmlsc_pkg::LANES*8-1:0]     rdata_b_i,
  output logic                                   issue_o,
  output logic      [bmlsc_pkg::ROW_BITS-1:0]    rrow_a_o,
  output logic      [bmlsc_pkg::ROW_BITS-1:0]    rrow_b_o,
  output bmlsc_pkg::walk_stat_t                  stat_o
);
  import bmlsc_pkg::*;

  logic [MEM_AW-1:0]    ptr_a_q, ptr_a_d;
  logic [MEM_AW-1:0]    ptr_b_q, ptr_b_d;
  logic [MEM_AW-1:0]    cnt_q, cnt_d;
  logic [31:0]          final_q, final_d;
  logic                 rvalid_q, rvalid_d;
  logic [LANE_BITS-1:0] lane_a_q, lane_b_q;

  logic [MEM_AW-1:0]    len_a, len_b;
  logic [MEM_AW:0]      len_diff;
  logic [7:0]           x, y;
  logic [8:0]           byte_diff;
  logic                 mismatch;
  logic                 done;

  // lengths of both ranges, inverted ranges count as empty
  assign len_a    = (ctrl_i.a_end > ctrl_i.a_start) ? (ctrl_i.a_end - ctrl_i.a_start) : '0;
  assign len_b    = (ctrl_i.b_end > ctrl_i.b_start) ? (ctrl_i.b_end - ctrl_i.b_start) : '0;
  assign len_diff = {1'b0, len_a} - {1'b0, len_b};

  assign x         = rdata_a_i[lane_a_q*8 +: 8];
  assign y         = rdata_b_i[lane_b_q*8 +: 8];
  assign byte_diff = {1'b0, x} - {1'b0, y};
  assign mismatch  = rvalid_q && (x != y);
  assign done      = ctrl_i.active && (mismatch || (cnt_q == '0));

  assign issue_o  = ctrl_i.active && !done;
  assign rrow_a_o = ptr_a_q[MEM_AW-1:LANE_BITS];
  assign rrow_b_o = ptr_b_q[MEM_AW-1:LANE_BITS];

  assign stat_o.done   = done;
  assign stat_o.result = mismatch ? {{23{byte_diff[8]}}, byte_diff} : final_q;

  always_comb begin
    ptr_a_d  = ptr_a_q;
    ptr_b_d  = ptr_b_q;
    cnt_d    = cnt_q;
    final_d  = final_q;
    rvalid_d = issue_o;
    if (ctrl_i.start) begin
      ptr_a_d  = ctrl_i.a_start;
      ptr_b_d  = ctrl_i.b_start;
      rvalid_d = 1'b0;
      if (ctrl_i.slice) begin
        cnt_d   = (len_a < len_b) ? len_a : len_b;
        final_d = {{(32-MEM_AW-1){len_diff[MEM_AW]}}, len_diff};
      end else begin
        cnt_d   = len_a;
        final_d = '0;
      end
    end else if (issue_o) begin
      // b wraps within the memory through the pointer width
      ptr_a_d = ptr_a_q + MEM_AW'(1);
      ptr_b_d = ptr_b_q + MEM_AW'(1);
      cnt_d   = cnt_q - MEM_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      rvalid_q <= rvalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_a_q <= ptr_a_d;
    ptr_b_q <= ptr_b_d;
    final_q <= final_d;
    if (issue_o) begin
      lane_a_q <= ptr_a_q[LANE_BITS-1:0];
      lane_b_q <= ptr_b_q[LANE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire
